// File: sv/union_find_engine_assert.svh
// ----------------------------------------------------------------------------
// union_find_engine_assert.svh
// Assertion macros for the union-find engine; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_ENGINE_ASSERT_SVH
`define UNION_FIND_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UFE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication
`define UFE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define UFE_ASSERT_IMP(label, clk, rst, ante, cons)
`define UFE_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/ufe_pkg.sv
// ----------------------------------------------------------------------------
// ufe_pkg
// Request kinds and field widths shared by the union-find engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ufe_pkg;

   localparam int NODE_W      = 10;
   localparam int MAX_ENTRIES = 2 ** NODE_W;
   localparam int AMOUNT_W    = 11;
   localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = '1;

   typedef enum logic [1:0] {
      KIND_MERGE = 2'd0,
      KIND_SAME  = 2'd1,
      KIND_SIZE  = 2'd2,
      KIND_COUNT = 2'd3
   } kind_type;

endpackage

`default_nettype wire

// File: sv/ufe_ram.sv
// ----------------------------------------------------------------------------
// ufe_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ufe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/union_find_engine.sv
// ----------------------------------------------------------------------------
// union_find_engine
// Disjoint-set forest with path compression, parent and size tables in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one item: kind (merge, same, size, count) and two
//   node indices. rsp_ channel returns one item per request: flag, amount.
//   Both channels use valid/stall; an item moves when valid=1 and stall=0.
// Work per item, one item at a time:
//   count or out-of-range request: no find; find: follows the links to
//   the root, then rewrites the path nodes (one parent RAM access per hop).
//   same: two finds and a root compare; size: one find and a size read;
//   merge: two finds, size reads and writes (two finds when already
//   joined). rsp_valid rises in the cycle the next request can be taken.
// Reset: a clearing pass over min(NODES, 1024) entries writes every parent
//   entry to itself and every size to one; req_stall stays high meanwhile.
// Receiver stall: a finished result waits in the output register; the
//   next request is taken and worked on, and holds in its final state
//   until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "union_find_engine_assert.svh"

module union_find_engine
   import ufe_pkg::*;
#(
   parameter int NODES = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_kind,
   input  wire logic [NODE_W-1:0]   req_node_a,
   input  wire logic [NODE_W-1:0]   req_node_b,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_flag,
   output logic [AMOUNT_W-1:0]      rsp_amount
);

   localparam int ENTRIES = (NODES < MAX_ENTRIES) ? NODES : MAX_ENTRIES;
   localparam int IW      = $clog2(ENTRIES);
   localparam int TW      = $clog2(NODES + 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_START, ST_WALK, ST_COMP,
      ST_FDONE, ST_OPER, ST_SZA, ST_SZB, ST_FIN
   } state_type;

   state_type            state_ff, state_in;
   logic [IW-1:0]        clr_ff, clr_in;
   kind_type             kind_ff, kind_in;
   logic [IW-1:0]        node_b_ff, node_b_in;
   logic                 op_ff, op_in;
   logic [IW-1:0]        cur_ff, cur_in;
   logic [IW-1:0]        start_ff, start_in;
   logic [IW-1:0]        root_ff, root_in;
   logic [IW-1:0]        ra_ff, ra_in;
   logic [IW-1:0]        rb_ff, rb_in;
   logic [AMOUNT_W-1:0]  sa_ff, sa_in;
   logic [TW-1:0]        total_ff, total_in;
   logic                 pend_flag_ff, pend_flag_in;
   logic [AMOUNT_W-1:0]  pend_amount_ff, pend_amount_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_flag_ff, rsp_flag_in;
   logic [AMOUNT_W-1:0]  rsp_amount_ff, rsp_amount_in;

   logic                 par_we;
   logic [IW-1:0]        par_wa, par_wd, par_ra, par_rd;
   logic                 sz_we;
   logic [IW-1:0]        sz_wa, sz_ra;
   logic [AMOUNT_W-1:0]  sz_wd, sz_rd;

   logic                 a_ok, b_ok;
   logic [31:0]          total_wide;
   logic [AMOUNT_W-1:0]  total_sat;

   ufe_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_parent (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_wa),
      .wr_data (par_wd),
      .rd_addr (par_ra),
      .rd_data (par_rd)
   );

   ufe_ram #(.WIDTH(AMOUNT_W), .DEPTH(ENTRIES)) u_size (
      .clock   (clock),
      .wr_en   (sz_we),
      .wr_addr (sz_wa),
      .wr_data (sz_wd),
      .rd_addr (sz_ra),
      .rd_data (sz_rd)
   );

   assign a_ok       = 32'(req_node_a) < NODES;
   assign b_ok       = 32'(req_node_b) < NODES;
   assign total_wide = 32'(total_ff);
   assign total_sat  = (total_wide > 32'(AMOUNT_MAX)) ? AMOUNT_MAX
                                                      : total_wide[AMOUNT_W-1:0];

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_flag   = rsp_flag_ff;
   assign rsp_amount = rsp_amount_ff;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      kind_in        = kind_ff;
      node_b_in      = node_b_ff;
      op_in          = op_ff;
      cur_in         = cur_ff;
      start_in       = start_ff;
      root_in        = root_ff;
      ra_in          = ra_ff;
      rb_in          = rb_ff;
      sa_in          = sa_ff;
      total_in       = total_ff;
      pend_flag_in   = pend_flag_ff;
      pend_amount_in = pend_amount_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_flag_in    = rsp_flag_ff;
      rsp_amount_in  = rsp_amount_ff;

      par_we = 1'b0;
      par_wa = cur_ff;
      par_wd = root_ff;
      par_ra = cur_ff;
      sz_we  = 1'b0;
      sz_wa  = ra_ff;
      sz_wd  = sa_ff + sz_rd;
      sz_ra  = ra_ff;

      case (state_ff)
         ST_CLEAR: begin
            par_we = 1'b1;
            par_wa = clr_ff;
            par_wd = clr_ff;
            sz_we  = 1'b1;
            sz_wa  = clr_ff;
            sz_wd  = AMOUNT_W'(1);
            clr_in = clr_ff + IW'(1);
            if (clr_ff == IW'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in        = kind_type'(req_kind);
               node_b_in      = req_node_b[IW-1:0];
               cur_in         = req_node_a[IW-1:0];
               op_in          = 1'b0;
               pend_flag_in   = 1'b0;
               pend_amount_in = '0;
               case (kind_type'(req_kind))
                  KIND_MERGE, KIND_SAME: begin
                     state_in = (a_ok && b_ok) ? ST_START : ST_FIN;
                  end
                  KIND_SIZE: begin
                     state_in = a_ok ? ST_START : ST_FIN;
                  end
                  default: begin
                     pend_amount_in = total_sat;
                     state_in       = ST_FIN;
                  end
               endcase
            end
         end
         ST_START: begin
            par_ra   = cur_ff;
            start_in = cur_ff;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (par_rd == cur_ff) begin
               root_in = cur_ff;
               if (cur_ff == start_ff) begin
                  state_in = ST_FDONE;
               end else begin
                  cur_in   = start_ff;
                  par_ra   = start_ff;
                  state_in = ST_COMP;
               end
            end else begin
               cur_in = par_rd;
               par_ra = par_rd;
            end
         end
         ST_COMP: begin
            par_we = 1'b1;
            par_wa = cur_ff;
            par_wd = root_ff;
            if (par_rd == root_ff) begin
               state_in = ST_FDONE;
            end else begin
               cur_in = par_rd;
               par_ra = par_rd;
            end
         end
         ST_FDONE: begin
            if (!op_ff) begin
               ra_in = root_ff;
               if (kind_ff == KIND_MERGE || kind_ff == KIND_SAME) begin
                  op_in    = 1'b1;
                  cur_in   = node_b_ff;
                  state_in = ST_START;
               end else begin
                  state_in = ST_OPER;
               end
            end else begin
               rb_in    = root_ff;
               state_in = ST_OPER;
            end
         end
         ST_OPER: begin
            case (kind_ff)
               KIND_SAME: begin
                  pend_flag_in = (ra_ff == rb_ff);
                  state_in     = ST_FIN;
               end
               KIND_MERGE: begin
                  sz_ra    = ra_ff;
                  state_in = (ra_ff == rb_ff) ? ST_FIN : ST_SZA;
               end
               default: begin
                  sz_ra    = ra_ff;
                  state_in = ST_SZA;
               end
            endcase
         end
         ST_SZA: begin
            sa_in = sz_rd;
            if (kind_ff == KIND_SIZE) begin
               pend_amount_in = sz_rd;
               state_in       = ST_FIN;
            end else begin
               sz_ra    = rb_ff;
               state_in = ST_SZB;
            end
         end
         ST_SZB: begin
            sz_we        = 1'b1;
            sz_wa        = ra_ff;
            sz_wd        = sa_ff + sz_rd;
            par_we       = 1'b1;
            par_wa       = rb_ff;
            par_wd       = ra_ff;
            total_in     = total_ff - TW'(1);
            pend_flag_in = 1'b1;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_flag_in   = pend_flag_ff;
               rsp_amount_in = pend_amount_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         total_ff     <= TW'(NODES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      node_b_ff      <= node_b_in;
      op_ff          <= op_in;
      cur_ff         <= cur_in;
      start_ff       <= start_in;
      root_ff        <= root_in;
      ra_ff          <= ra_in;
      rb_ff          <= rb_in;
      sa_ff          <= sa_in;
      pend_flag_ff   <= pend_flag_in;
      pend_amount_ff <= pend_amount_in;
      rsp_flag_ff    <= rsp_flag_in;
      rsp_amount_ff  <= rsp_amount_in;
   end

   // a successful merge removes exactly one set
   `UFE_ASSERT_NXT(a_merge_total, clock, reset, state_ff == ST_SZB, total_ff == $past(total_ff) - TW'(1))

   // compression never writes the entry it reads in the same cycle
   `UFE_ASSERT_IMP(a_comp_ports, clock, reset, state_ff == ST_COMP && par_rd != root_ff, par_wa != par_ra)

   // a new result appears only out of the final state
   `UFE_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FIN)

endmodule

`default_nettype wire
